FILE: rtl/abpc_pkg.sv
package abpc_pkg;

    // Pixel and channel geometry
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned PROD_W  = 2 * CH_W;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned CFG_W   = RGB_W;
    localparam int unsigned CFG_IDX_W = 1;

    // Alpha codes
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAY_MODE = 1'b0,
        CFG_KEY_COLOUR   = 1'b1
    } abpc_cfg_idx_t;

endpackage

FILE: rtl/abpc_in_if.sv
interface abpc_in_if
    import abpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] source_pixel;
    logic [PIX_W-1:0] background_pixel;

    modport source (output valid, output source_pixel, output background_pixel, input ready);
    modport sink   (input valid, input source_pixel, input background_pixel, output ready);
endinterface

FILE: rtl/abpc_out_if.sv
interface abpc_out_if
    import abpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             write_enable;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output write_enable, output pixel_out, input ready);
    modport sink   (input valid, input write_enable, input pixel_out, output ready);
endinterface

FILE: rtl/abpc_chan_mix.sv
module abpc_chan_mix
    import abpc_pkg::*;
(
    input  logic            clk,
    input  logic            load,
    input  logic [CH_W-1:0] alpha,
    input  logic [CH_W-1:0] fg,
    input  logic [CH_W-1:0] bg,
    output logic [CH_W-1:0] mix
);

    logic [CH_W-1:0]   inv_alpha;
    logic [PROD_W-1:0] fg_prod_reg;
    logic [PROD_W-1:0] fg_prod_next;
    logic [PROD_W-1:0] bg_prod_reg;
    logic [PROD_W-1:0] bg_prod_next;
    logic [PROD_W-1:0] sum;

    // Weight each side; 255 - a is the bitwise complement of a
    always_comb
    begin
        inv_alpha    = ~alpha;
        fg_prod_next = PROD_W'(fg) * PROD_W'(alpha);
        bg_prod_next = PROD_W'(bg) * PROD_W'(inv_alpha);
    end

    // Hold the products while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fg_prod_reg <= fg_prod_next;
            bg_prod_reg <= bg_prod_next;
        end
    end

    // Sum stays within 255*255, so the high byte is the blended channel
    always_comb
    begin
        sum = fg_prod_reg + bg_prod_reg;
        mix = sum[PROD_W-1:CH_W];
    end

endmodule

FILE: rtl/alpha_blend_pixel_compositor.sv
// Alpha-blend compositor: draws an ARGB source pixel over an opaque background.
// Input channel in_ch carries source_pixel and background_pixel; output
// channel out_ch carries write_enable and pixel_out (pixel_out is zero when
// write_enable is low). Both use valid/ready; a beat moves when both are high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0
// is overlay_mode, index 1 is key_colour. Write it only while the pipe is empty.
// Pipeline: stage 1 decides the write, stage 2 registers the 8x8 channel
// products, and stage 3 sums them and registers the result.
// Throughput: one pixel per cycle while out_ch.ready is high; each stage advances
// when it is empty or the stage after it advances, so bubbles collapse.
// Stall: when out_ch.ready is low the result holds, and the pipe keeps
// accepting until all three stages are full; in_ch.ready then drops.
// Reset clears all valid bits and both configuration registers to zero.
module alpha_blend_pixel_compositor
    import abpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    abpc_in_if.sink              in_ch,
    abpc_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic             overlay_mode_reg;
    logic [RGB_W-1:0] key_colour_reg;

    logic             s1_en;
    logic             s2_en;
    logic             s3_en;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_fg_reg;
    logic [PIX_W-1:0] s1_bg_reg;
    logic             s1_we_reg;
    logic             s1_we_next;
    logic             s1_pass_reg;
    logic             s1_pass_next;

    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic [PIX_W-1:0] s2_fg_reg;
    logic             s2_we_reg;
    logic             s2_pass_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_we_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic [PIX_W-1:0] out_pix_next;

    logic [CH_W-1:0]  mix_r;
    logic [CH_W-1:0]  mix_g;
    logic [CH_W-1:0]  mix_b;
    logic [CH_W-1:0]  s1_alpha;
    logic [CH_W-1:0]  in_alpha;
    logic             allowed;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_mode_reg <= 1'b0;
            key_colour_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OVERLAY_MODE: overlay_mode_reg <= cfg_data[0];
                CFG_KEY_COLOUR:   key_colour_reg   <= cfg_data[RGB_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stage enables: advance when empty or when downstream advances
    always_comb
    begin
        s3_en = !out_valid_reg || out_ch.ready;
        s2_en = !s2_valid_reg || s3_en;
        s1_en = !s1_valid_reg || s2_en;
    end

    assign in_ch.ready = s1_en;

    // Stage 1: decide whether the pixel is written or passed through, and step the valid bits
    always_comb
    begin
        in_alpha      = in_ch.source_pixel[PIX_W-1:PIX_W-CH_W];
        allowed       = !overlay_mode_reg
                        || (in_ch.background_pixel[RGB_W-1:0] == key_colour_reg);
        s1_we_next    = allowed && (in_alpha != ALPHA_CLEAR);
        s1_pass_next  = (in_alpha == ALPHA_OPAQUE);
        s1_valid_next = s1_en ? in_ch.valid : s1_valid_reg;
        s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;
        out_valid_next = s3_en ? s2_valid_reg : out_valid_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_fg_reg   <= in_ch.source_pixel;
            s1_bg_reg   <= in_ch.background_pixel;
            s1_we_reg   <= s1_we_next;
            s1_pass_reg <= s1_pass_next;
        end
    end

    assign s1_alpha = s1_fg_reg[PIX_W-1:PIX_W-CH_W];

    // Stage 2: per-channel products (registered inside each lane)
    abpc_chan_mix u_mix_r (
        .clk   (clk),
        .load  (s2_en),
        .alpha (s1_alpha),
        .fg    (s1_fg_reg[3*CH_W-1:2*CH_W]),
        .bg    (s1_bg_reg[3*CH_W-1:2*CH_W]),
        .mix   (mix_r)
    );

    abpc_chan_mix u_mix_g (
        .clk   (clk),
        .load  (s2_en),
        .alpha (s1_alpha),
        .fg    (s1_fg_reg[2*CH_W-1:CH_W]),
        .bg    (s1_bg_reg[2*CH_W-1:CH_W]),
        .mix   (mix_g)
    );

    abpc_chan_mix u_mix_b (
        .clk   (clk),
        .load  (s2_en),
        .alpha (s1_alpha),
        .fg    (s1_fg_reg[CH_W-1:0]),
        .bg    (s1_bg_reg[CH_W-1:0]),
        .mix   (mix_b)
    );

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_fg_reg   <= s1_fg_reg;
            s2_we_reg   <= s1_we_reg;
            s2_pass_reg <= s1_pass_reg;
        end
    end

    // Stage 3: pick pass-through or blended pixel, zero when not written
    always_comb
    begin
        if (!s2_we_reg)
        begin
            out_pix_next = '0;
        end
        else if (s2_pass_reg)
        begin
            out_pix_next = s2_fg_reg;
        end
        else
        begin
            out_pix_next = {ALPHA_OPAQUE, mix_r, mix_g, mix_b};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            out_we_reg  <= s2_we_reg;
            out_pix_reg <= out_pix_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.write_enable = out_we_reg;
    assign out_ch.pixel_out    = out_pix_reg;

    // A beat leaving stage 2 lands in the output register
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_en) |=> out_ch.valid)
        else $error("stage 2 beat lost on its way to the output");

    // A skipped pixel carries a zero payload
    a_zero_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.write_enable) |-> (out_ch.pixel_out == '0))
        else $error("non-zero pixel on a beat without write");

    // Every written pixel is opaque
    a_opaque_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.write_enable)
            |-> (out_ch.pixel_out[PIX_W-1:PIX_W-CH_W] == ALPHA_OPAQUE))
        else $error("written pixel is not opaque");

endmodule
